// ===== rtl/vsps_pkg.sv =====
// Shared constants, types and helpers for the voxel SDF point sampler.
package vsps_pkg;

  localparam int MAX_DIM    = 32;
  localparam int GRID_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int DIM_W      = 6;
  localparam int SAMPLE_W   = 32;
  localparam int DVD_W      = 64;
  localparam int DSR_W      = 33;
  localparam int CNT_W      = 7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CFG_DIM_X       = 3'd0,
    CFG_DIM_Y       = 3'd1,
    CFG_DIM_Z       = 3'd2,
    CFG_CELL_EDGE   = 3'd3,
    CFG_GRID_ORIGIN = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_AXIS, S_AXDIV, S_PREP, S_OFF, S_SQ, S_ACC, S_SQRT,
    S_WDIV, S_MUL, S_MAC, S_NEXT, S_FIN, S_FDIV, S_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [DSR_W-1:0]   divisor;
    logic [CNT_W-1:0]   nbits;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Clamp a configured dimension to the grid size.
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
    if (d > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

// ===== rtl/vsps_grid_mem.sv =====
// Sample grid memory: one write port, one registered read port.
module vsps_grid_mem (
  input  logic                           clk,
  input  logic                           we,
  input  logic [vsps_pkg::ADDR_W-1:0]    waddr,
  input  logic [vsps_pkg::SAMPLE_W-1:0]  wdata,
  input  logic                           re,
  input  logic [vsps_pkg::ADDR_W-1:0]    raddr,
  output logic [vsps_pkg::SAMPLE_W-1:0]  rdata
);
  import vsps_pkg::*;

  logic [SAMPLE_W-1:0] mem [GRID_DEPTH];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/vsps_div.sv =====
// Restoring divider, one quotient bit per cycle, over the low nbits of the dividend.
module vsps_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vsps_pkg::div_req_t           req,
  output vsps_pkg::unit_stat_t         stat,
  output logic [vsps_pkg::DVD_W-1:0]   quot
);
  import vsps_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DSR_W:0]     rem_r, rem_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [DSR_W-1:0]   dsr_r, dsr_nxt;
  logic [DSR_W:0]     cand;
  logic [DSR_W:0]     diff;
  logic               ge;

  always_comb begin
    cand     = {rem_r[DSR_W-1:0], dvd_r[DVD_W-1]};
    ge       = cand >= {1'b0, dsr_r};
    diff     = cand - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      // upper part of the dividend is known to be below the divisor
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      rem_nxt  = (DSR_W+1)'(req.dividend >> req.nbits);
      dvd_nxt  = req.dividend << (CNT_W'(DVD_W) - req.nbits);
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff : cand;
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = dvd_r;

endmodule

// ===== rtl/vsps_isqrt.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
module vsps_isqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           value,
  output vsps_pkg::unit_stat_t  stat,
  output logic [31:0]           root
);
  import vsps_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [63:0] trial;

  always_comb begin
    trial    = r_r + bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    v_nxt    = v_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      v_nxt    = value;
      r_nxt    = '0;
      bit_nxt  = 64'd1 << 62;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt = v_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 64'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = r_r[31:0];

endmodule

// ===== rtl/voxel_sdf_point_sample_top.sv =====
// Voxel SDF point sampler: a load word writes one grid entry.
// A query word runs one neighbor at a time through the grid memory, the shared
// restoring divider and the bit-serial square root: a cell search of three
// 32-step divides, then a 32-step root and a 17-step weight divide per visited
// neighbor, up to 27 neighbors, and a 33-step final divide; an out-of-grid
// query finishes within the cell search. Loads are taken back to back. A finished
// result waits in the output register while the next word is accepted.
module voxel_sdf_point_sample_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [14:0]                    in_sample_index,
  input  logic signed [31:0]             in_sample_value,
  input  logic signed [31:0]             in_pos_x,
  input  logic signed [31:0]             in_pos_y,
  input  logic signed [31:0]             in_pos_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_distance_value,
  output logic                           out_out_of_range,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [31:0]                    cfg_data
);
  import vsps_pkg::*;

  // configuration
  logic [DIM_W-1:0] dim_x_r, dim_y_r, dim_z_r;
  logic [30:0]      edge_r;
  logic [31:0]      origin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r  <= DIM_W'(32);
      dim_y_r  <= DIM_W'(32);
      dim_z_r  <= DIM_W'(32);
      edge_r   <= 31'd65536;
      origin_r <= 32'hFFFE_0000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIM_X:       dim_x_r  <= cfg_data[DIM_W-1:0];
        CFG_DIM_Y:       dim_y_r  <= cfg_data[DIM_W-1:0];
        CFG_DIM_Z:       dim_z_r  <= cfg_data[DIM_W-1:0];
        CFG_CELL_EDGE:   edge_r   <= cfg_data[30:0];
        CFG_GRID_ORIGIN: origin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] dims [3];
  logic [31:0]      edge2;

  assign dims[0] = sat_dim(dim_x_r);
  assign dims[1] = sat_dim(dim_y_r);
  assign dims[2] = sat_dim(dim_z_r);
  assign edge2   = {edge_r, 1'b0};

  // datapath state
  state_t              state_r, state_nxt;
  logic [1:0]          ax_r, ax_nxt;
  logic [31:0]         pos_r [3];
  logic [31:0]         pos_nxt [3];
  logic [31:0]         dd_r [3];
  logic [31:0]         dd_nxt [3];
  logic [COORD_W-1:0]  lo_r [3];
  logic [COORD_W-1:0]  lo_nxt [3];
  logic [COORD_W-1:0]  hi_r [3];
  logic [COORD_W-1:0]  hi_nxt [3];
  logic [COORD_W-1:0]  cur_r [3];
  logic [COORD_W-1:0]  cur_nxt [3];
  logic [31:0]         ex_r [3];
  logic [31:0]         ex_nxt [3];
  logic [63:0]         lim_r, lim_nxt;
  logic [63:0]         sq_r, sq_nxt;
  logic [65:0]         s_r, s_nxt;
  logic [16:0]         wq_r, wq_nxt;
  logic signed [49:0]  prod_r, prod_nxt;
  logic signed [55:0]  num_r, num_nxt;
  logic [20:0]         den_r, den_nxt;
  logic [31:0]         res_dist_r, res_dist_nxt;
  logic                res_oor_r, res_oor_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_dist_r, out_dist_nxt;
  logic                out_oor_r, out_oor_nxt;

  // unit interfaces
  div_req_t            div_req;
  unit_stat_t          div_stat;
  logic [DVD_W-1:0]    div_quot;
  logic                sq_start;
  logic [63:0]         sq_value;
  unit_stat_t          sq_stat;
  logic [31:0]         sq_root;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [SAMPLE_W-1:0] mem_rdata;

  // combinational temporaries
  logic                in_acc;
  logic signed [32:0]  d_ax;
  logic [DIM_W-1:0]    dim_ax;
  logic [COORD_W-1:0]  cell_idx;
  logic [36:0]         cen;
  logic signed [38:0]  e_off;
  logic [38:0]         e_abs;
  logic [55:0]         mag;
  logic [31:0]         q32;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign mem_we   = in_acc && (in_op == OP_LOAD);

  assign mem_raddr = ADDR_W'(ADDR_W'(ADDR_W'(cur_r[0]) * ADDR_W'(dims[1]) + ADDR_W'(cur_r[1]))
                     * ADDR_W'(dims[2])) + ADDR_W'(cur_r[2]);

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    pos_nxt       = pos_r;
    dd_nxt        = dd_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    ex_nxt        = ex_r;
    lim_nxt       = lim_r;
    sq_nxt        = sq_r;
    s_nxt         = s_r;
    wq_nxt        = wq_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    res_dist_nxt  = res_dist_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dist_nxt  = out_dist_r;
    out_oor_nxt   = out_oor_r;
    div_req       = '0;
    sq_start      = 1'b0;
    sq_value      = s_nxt[63:0];
    mem_re        = 1'b0;
    d_ax          = $signed({pos_r[ax_r][31], pos_r[ax_r]}) - $signed({origin_r[31], origin_r});
    dim_ax        = dims[ax_r];
    cell_idx      = div_quot[COORD_W-1:0];
    cen           = 37'(edge_r) * 37'({cur_r[ax_r], 1'b1});
    e_off         = $signed({6'd0, dd_r[ax_r], 1'b0}) - $signed({2'd0, cen});
    e_abs         = e_off[38] ? 39'(-e_off) : 39'(e_off);
    mag           = num_r[55] ? 56'(-num_r) : 56'(num_r);
    q32           = div_quot[31:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_op == OP_QUERY)) begin
          pos_nxt[0] = in_pos_x;
          pos_nxt[1] = in_pos_y;
          pos_nxt[2] = in_pos_z;
          ax_nxt     = '0;
          if (edge_r == '0) begin
            res_dist_nxt = '0;
            res_oor_nxt  = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = S_AXIS;
          end
        end
      end
      S_AXIS: begin
        if (d_ax[32] || (dim_ax == '0)) begin
          res_dist_nxt = '0;
          res_oor_nxt  = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          dd_nxt[ax_r]     = d_ax[31:0];
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'(d_ax[31:0]);
          div_req.divisor  = DSR_W'(edge_r);
          div_req.nbits    = CNT_W'(32);
          state_nxt        = S_AXDIV;
        end
      end
      S_AXDIV: begin
        if (div_stat.done) begin
          if (div_quot >= DVD_W'(dim_ax)) begin
            res_dist_nxt = '0;
            res_oor_nxt  = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            lo_nxt[ax_r] = (cell_idx != '0) ? cell_idx - COORD_W'(1) : cell_idx;
            hi_nxt[ax_r] = ((DIM_W'(cell_idx) + DIM_W'(1)) < dim_ax) ?
                           cell_idx + COORD_W'(1) : cell_idx;
            if (ax_r == 2'd2) begin
              state_nxt = S_PREP;
            end else begin
              ax_nxt    = ax_r + 2'd1;
              state_nxt = S_AXIS;
            end
          end
        end
      end
      S_PREP: begin
        lim_nxt   = 64'(edge2) * 64'(edge2);
        cur_nxt   = lo_r;
        num_nxt   = '0;
        den_nxt   = '0;
        ax_nxt    = '0;
        state_nxt = S_OFF;
      end
      S_OFF: begin
        // drop the neighbor as soon as one axis is a full weight radius away
        if (e_abs >= 39'(edge2)) begin
          state_nxt = S_NEXT;
        end else begin
          ex_nxt[ax_r] = e_abs[31:0];
          if (ax_r == 2'd2) begin
            ax_nxt    = '0;
            s_nxt     = '0;
            state_nxt = S_SQ;
          end else begin
            ax_nxt = ax_r + 2'd1;
          end
        end
      end
      S_SQ: begin
        sq_nxt    = 64'(ex_r[ax_r]) * 64'(ex_r[ax_r]);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        s_nxt = s_r + 66'(sq_r);
        if (ax_r == 2'd2) begin
          if (s_nxt >= 66'(lim_r)) begin
            state_nxt = S_NEXT;
          end else begin
            sq_start  = 1'b1;
            sq_value  = s_nxt[63:0];
            mem_re    = 1'b1;
            state_nxt = S_SQRT;
          end
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_SQRT: begin
        if (sq_stat.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'({33'(edge2) - 33'(sq_root), 16'd0});
          div_req.divisor  = DSR_W'(edge2);
          div_req.nbits    = CNT_W'(17);
          state_nxt        = S_WDIV;
        end
      end
      S_WDIV: begin
        if (div_stat.done) begin
          wq_nxt    = div_quot[16:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = $signed({1'b0, wq_r}) * $signed(mem_rdata);
        state_nxt = S_MAC;
      end
      S_MAC: begin
        num_nxt   = num_r + 56'(prod_r);
        den_nxt   = den_r + 21'(wq_r);
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        // advance z fastest, then y, then x
        ax_nxt    = '0;
        state_nxt = S_OFF;
        if (cur_r[2] != hi_r[2]) begin
          cur_nxt[2] = cur_r[2] + COORD_W'(1);
        end else begin
          cur_nxt[2] = lo_r[2];
          if (cur_r[1] != hi_r[1]) begin
            cur_nxt[1] = cur_r[1] + COORD_W'(1);
          end else begin
            cur_nxt[1] = lo_r[1];
            if (cur_r[0] != hi_r[0]) begin
              cur_nxt[0] = cur_r[0] + COORD_W'(1);
            end else begin
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (den_r == '0) begin
          res_dist_nxt = '0;
          res_oor_nxt  = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'(mag) + DVD_W'(den_r >> 1);
          div_req.divisor  = DSR_W'(den_r);
          div_req.nbits    = CNT_W'(33);
          state_nxt        = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_stat.done) begin
          res_dist_nxt = num_r[55] ? -q32 : q32;
          res_oor_nxt  = 1'b0;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = res_dist_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r       <= ax_nxt;
    pos_r      <= pos_nxt;
    dd_r       <= dd_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cur_r      <= cur_nxt;
    ex_r       <= ex_nxt;
    lim_r      <= lim_nxt;
    sq_r       <= sq_nxt;
    s_r        <= s_nxt;
    wq_r       <= wq_nxt;
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    res_dist_r <= res_dist_nxt;
    res_oor_r  <= res_oor_nxt;
    out_dist_r <= out_dist_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  vsps_grid_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_sample_index),
    .wdata (in_sample_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  vsps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  vsps_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  assign out_valid          = out_valid_r;
  assign out_distance_value = out_dist_r;
  assign out_out_of_range   = out_oor_r;

`ifndef NO_ASSERTIONS
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |-> out_dist_r == '0)
    else $error("out-of-range word with nonzero distance");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_stat.busy)
    else $error("square root started while busy");
`endif

endmodule
